// ===== sv/hms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hms_pkg;

  // Size of the byte store
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW    = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  // Command-address header
  localparam logic [2:0] HEADER_LEN   = 3'd6;
  localparam int unsigned CMD_READ_BIT = 47;

  // Value of an erased byte
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Request codes
  typedef enum logic {
    OP_CS   = 1'b0,
    OP_BYTE = 1'b1
  } op_t;

endpackage

`default_nettype wire

// ===== sv/hyperbus_memory_slave.sv =====
// Latency: a request is accepted and its result, if any, is valid on the next cycle.
// Throughput: one request per cycle unless a result stalls; each in-range data beat
// is one access to the single-port store. Reset: control state clears at once, then the byte
// store is swept to 0xFF, one byte per cycle over MEM_BYTES (65536) bytes, with in_ready low.
`timescale 1ns / 1ps
`default_nettype none

module hyperbus_memory_slave (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [7:0] bus_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_byte,
  output logic            out_of_range
);

  localparam logic [hms_pkg::MEM_AW-1:0] LAST_ADDR =
    hms_pkg::MEM_AW'(hms_pkg::MEM_BYTES - 1);

  logic [7:0] mem [hms_pkg::MEM_BYTES];
  logic [7:0] mem_q;

  // Sweep state after reset
  logic                      clearing;
  logic [hms_pkg::MEM_AW-1:0] clr_addr;

  // Transaction state
  logic        in_data_phase;
  logic [2:0]  header_bytes_left;
  logic [47:0] command_word;
  logic [31:0] beat_address;
  logic        oor_q;

  logic        accept;
  logic        is_cs;
  logic        is_beat;
  logic        beat_in_range;
  logic        is_read;
  logic        has_result;
  logic        wr_en;
  logic        rd_en;
  logic [hms_pkg::MEM_AW-1:0] mem_idx;
  logic [47:0] command_word_next;
  logic [2:0]  header_bytes_left_next;

  // Decode of the request against current state
  always_comb begin
    in_ready      = !clearing && (!out_valid || out_ready);
    accept        = in_valid && in_ready;
    is_cs         = (hms_pkg::op_t'(op) == hms_pkg::OP_CS);
    is_beat       = !is_cs && in_data_phase;
    beat_in_range = (beat_address < 32'(hms_pkg::MEM_BYTES));
    is_read       = command_word[hms_pkg::CMD_READ_BIT];
    has_result    = is_beat && (is_read || !beat_in_range);
    wr_en         = accept && is_beat && beat_in_range && !is_read;
    rd_en         = accept && is_beat && beat_in_range && is_read;
    mem_idx       = beat_address[hms_pkg::MEM_AW-1:0];
    command_word_next = {command_word[39:0], bus_byte};
    header_bytes_left_next = (header_bytes_left != 3'd0) ?
                             header_bytes_left - 3'd1 : 3'd0;
  end

  // Control and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing          <= 1'b1;
      clr_addr          <= '0;
      in_data_phase     <= 1'b0;
      header_bytes_left <= hms_pkg::HEADER_LEN;
      command_word      <= '0;
      beat_address      <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + hms_pkg::MEM_AW'(1);
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end

      if (accept) begin
        if (is_cs) begin
          in_data_phase     <= 1'b0;
          header_bytes_left <= hms_pkg::HEADER_LEN;
        end else if (!in_data_phase) begin
          command_word      <= command_word_next;
          header_bytes_left <= header_bytes_left_next;
          if (header_bytes_left_next == 3'd0) begin
            in_data_phase <= 1'b1;
            beat_address  <= {command_word_next[44:16], command_word_next[2:0]};
          end
        end else begin
          beat_address <= beat_address + 32'd1;
        end
      end

      // Result register: load on a beat with a result, else clear once taken
      if (accept && has_result) begin
        out_valid <= 1'b1;
        oor_q     <= !beat_in_range;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Byte store, single port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= hms_pkg::ERASED_BYTE;
    end else if (wr_en) begin
      mem[mem_idx] <= bus_byte;
    end
    if (rd_en) begin
      mem_q <= mem[mem_idx];
    end
  end

  assign out_of_range = oor_q;
  assign read_byte    = oor_q ? 8'd0 : mem_q;

endmodule

`default_nettype wire

// ===== sv/hyperbus_memory_slave_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hyperbus_memory_slave_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       op,
  input wire logic [7:0] bus_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_byte,
  input wire logic       out_of_range
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(out_of_range))
    else $error("result changed while stalled");

  // Out-of-range results carry a zero byte
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> read_byte == 8'd0)
    else $error("out-of-range result with nonzero byte");

  // A chip-select request never yields a result
  a_cs_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (hms_pkg::op_t'(op) == hms_pkg::OP_CS) |=> !out_valid)
    else $error("result after chip-select");

  // Store sweep blocks requests right after reset
  a_rst_block: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("request taken during store sweep");

  // Requests are taken only when the result register is free
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("request taken while result stalled");

endmodule

bind hyperbus_memory_slave hyperbus_memory_slave_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .op           (op),
  .bus_byte     (bus_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_byte    (read_byte),
  .out_of_range (out_of_range)
);

`default_nettype wire

// ===== sim/hyperbus_slave_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps a model of the memory device and
// compares every returned beat with the model's prediction.
module hyperbus_slave_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       op,
  input  logic [7:0] bus_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] read_byte,
  input  logic       out_of_range,
  output int         mismatches,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       oor;
  } beat_result_t;

  // Expected read results, oldest first
  beat_result_t expected_beats[$];
  beat_result_t want;
  int           fail_total;

  // Model state
  logic [7:0]   mem_image [hms_pkg::MEM_BYTES];
  logic         in_data;
  logic [2:0]   hdr_left;
  logic [47:0]  cmd_word;
  logic [31:0]  beat_addr;

  // Advance the model by one accepted request
  task automatic track_request(input hms_pkg::op_t o, input logic [7:0] b);
    beat_result_t res;
    if (o == hms_pkg::OP_CS) begin
      in_data  = 1'b0;
      hdr_left = hms_pkg::HEADER_LEN;
    end else if (!in_data) begin
      // header byte, MSB first
      cmd_word = {cmd_word[39:0], b};
      if (hdr_left != 3'd0) hdr_left = hdr_left - 3'd1;
      if (hdr_left == 3'd0) begin
        in_data   = 1'b1;
        beat_addr = {cmd_word[44:16], cmd_word[2:0]};
      end
    end else begin
      // data beat
      if (beat_addr >= hms_pkg::MEM_BYTES) begin
        res.data = 8'h00;
        res.oor  = 1'b1;
        expected_beats.push_back(res);
      end else if (cmd_word[hms_pkg::CMD_READ_BIT]) begin
        res.data = mem_image[beat_addr[hms_pkg::MEM_AW-1:0]];
        res.oor  = 1'b0;
        expected_beats.push_back(res);
      end else begin
        mem_image[beat_addr[hms_pkg::MEM_AW-1:0]] = b;
      end
      beat_addr = beat_addr + 32'd1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_data   = 1'b0;
      hdr_left  = hms_pkg::HEADER_LEN;
      cmd_word  = '0;
      beat_addr = '0;
      for (int a = 0; a < hms_pkg::MEM_BYTES; a++) mem_image[a] = hms_pkg::ERASED_BYTE;
      expected_beats.delete();
      fail_total = 0;
    end else begin
      // results first: a request's result never shows up on its own edge
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result: read_byte %h out_of_range %b",
                   $time, read_byte, out_of_range);
          fail_total++;
        end else begin
          want = expected_beats.pop_front();
          if (read_byte !== want.data) begin
            $display("%0t: read_byte mismatch: expected %h, got %h",
                     $time, want.data, read_byte);
            fail_total++;
          end
          if (out_of_range !== want.oor) begin
            $display("%0t: out_of_range mismatch: expected %b, got %b",
                     $time, want.oor, out_of_range);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) track_request(hms_pkg::op_t'(op), bus_byte);
    end
    mismatches <= fail_total;
    pending    <= expected_beats.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 200000;
  localparam int ITEM_TARGET = 800;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       op;
  logic [7:0] bus_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_byte;
  logic       out_of_range;

  int mismatches;
  int pending;
  int sent;
  int stall_cycles;
  int next_pause;
  int pick;
  bit steady;

  hyperbus_memory_slave u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .bus_byte     (bus_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .out_of_range (out_of_range)
  );

  hyperbus_slave_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .bus_byte     (bus_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_byte    (read_byte),
    .out_of_range (out_of_range),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: stalls about a quarter of the time, none in the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // One request, with a random gap ahead of it
  task automatic send(input hms_pkg::op_t o, input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    bus_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Optional chip select, then the six header bytes with random ignored bits
  task automatic open_burst(input bit with_cs, input bit rd, input logic [31:0] addr);
    logic [1:0]  spare;
    logic [12:0] rsvd;
    logic [47:0] cw;
    spare = 2'($urandom);
    rsvd  = 13'($urandom);
    cw    = {rd, spare, addr[31:3], rsvd, addr[2:0]};
    if (with_cs) send(hms_pkg::OP_CS, 8'($urandom));
    for (int i = 5; i >= 0; i--) send(hms_pkg::OP_BYTE, cw[i*8 +: 8]);
  endtask

  task automatic data_beats(input int n);
    repeat (n) send(hms_pkg::OP_BYTE, 8'($urandom));
  endtask

  // Hold off until every expected read has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Start addresses: a hot region so reads find earlier writes, the top
  // of memory, anywhere, far out of range, and the 32-bit wrap
  function automatic logic [31:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 255);
    if (r < 65) return hms_pkg::MEM_BYTES - $urandom_range(1, 24);
    if (r < 80) return $urandom_range(0, hms_pkg::MEM_BYTES - 1);
    if (r < 92) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 12);
  endfunction

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= hms_pkg::OP_CS;
    bus_byte   <= 8'h00;
    out_ready  <= 1'b0;
    steady     = 1'b0;
    sent       = 0;
    stall_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // header right after reset, no chip select: write last byte, then past the end
    open_burst(1'b0, 1'b0, hms_pkg::MEM_BYTES - 1);
    send(hms_pkg::OP_BYTE, 8'h00);
    send(hms_pkg::OP_BYTE, 8'hFF);
    // read it back, then one beat out of range
    open_burst(1'b1, 1'b1, hms_pkg::MEM_BYTES - 1);
    data_beats(2);
    // chip select cuts a header short, then a read that wraps past 2^32 to zero
    send(hms_pkg::OP_CS, 8'hFF);
    data_beats(3);
    open_burst(1'b1, 1'b1, 32'hFFFF_FFFF);
    data_beats(2);
    drain();

    // random traffic
    next_pause = 200;
    while (sent < ITEM_TARGET) begin
      steady = (sent >= 300 && sent < 450);
      pick   = $urandom_range(0, 99);
      if (pick < 80) begin
        open_burst($urandom_range(0, 9) != 0, $urandom_range(0, 1), pick_addr());
        if ($urandom_range(0, 9) == 0) data_beats($urandom_range(9, 40));
        else data_beats($urandom_range(1, 8));
      end else if (pick < 90) begin
        // header broken off by a chip select
        send(hms_pkg::OP_CS, 8'($urandom));
        data_beats($urandom_range(1, 5));
      end else begin
        repeat ($urandom_range(1, 8))
          send(hms_pkg::op_t'($urandom_range(0, 1)), 8'($urandom));
      end
      if (sent >= next_pause) begin
        drain();
        next_pause += 200;
      end
    end
    steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
